// ===== rtl/core/sha1_hash_engine_assert.svh =====
// Assertion macros for the SHA-1 hash engine.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Check a property on the rising clock edge, disabled during reset.
`define SHA1_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SHA1_ASSERT_IMP(lbl, ante, cons, msg) \
  `SHA1_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another in the following cycle.
`define SHA1_ASSERT_NXT(lbl, ante, cons, msg) \
  `SHA1_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/sha1_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int unsigned RND_W = 7;
  localparam logic [RND_W-1:0] RND_PH1 = 7'd20;
  localparam logic [RND_W-1:0] RND_PH2 = 7'd40;
  localparam logic [RND_W-1:0] RND_PH3 = 7'd60;
  localparam logic [RND_W-1:0] RND_LAST = 7'd79;

  localparam int unsigned BLK_W = 55;
  localparam logic [5:0] FILL_LEN_AT = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd4;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

endpackage

// ===== rtl/core/sha1_round.sv =====
// One SHA-1 round and the next message schedule word.
module sha1_round (
  input  sha1_pkg::work_t                  work_i,
  input  logic [sha1_pkg::RND_W-1:0]       rnd_i,
  input  logic [511:0]                     win_i,
  output sha1_pkg::work_t                  work_o,
  output logic [31:0]                      wnew_o
);

  logic [31:0] wt;
  logic [31:0] mix;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  assign wt  = win_i[511:480];
  assign mix = win_i[95:64] ^ win_i[255:224] ^ win_i[447:416] ^ wt;
  assign wnew_o = {mix[30:0], mix[31]};

  always_comb begin
    if (rnd_i < sha1_pkg::RND_PH1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = sha1_pkg::K0;
    end else if (rnd_i < sha1_pkg::RND_PH2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::K1;
    end else if (rnd_i < sha1_pkg::RND_PH3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = sha1_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1_pkg::K3;
    end
  end

  assign t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + wt;

  assign work_o.a = t;
  assign work_o.b = work_i.a;
  assign work_o.c = {work_i.b[1:0], work_i.b[31:2]};
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

endmodule

// ===== rtl/core/sha1_hash_engine.sv =====
// Top level of the byte-stream SHA-1 hash engine.
// Absorb transaction: the 64th byte of a block also starts its compression (80 rounds, then the add).
// Finish transaction: one pad or length byte per cycle to the block end, through a second block
// when the length no longer fits, each full block compressed on the way, then five words.
// The single round unit sets the sustained rate; no new byte is taken while a block is compressed.
// Reset (async, active low) loads the IV and clears counters; the buffer is not cleared.
`include "sha1_hash_engine_assert.svh"

module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e                        state_q, state_d;
  state_e                        ret_q, ret_d;
  logic [5:0]                    fill_q, fill_d;
  logic [sha1_pkg::BLK_W-1:0]    blk_q, blk_d;
  logic                          mark_q, mark_d;
  logic [sha1_pkg::RND_W-1:0]    rnd_q, rnd_d;
  logic [2:0]                    idx_q, idx_d;
  logic [31:0]                   h_q [5];
  logic [31:0]                   h_d [5];
  logic [511:0]                  buf_q, buf_d;
  logic [63:0]                   len_q, len_d;
  sha1_pkg::work_t               wk_q, wk_d;

  sha1_pkg::work_t               wk_next;
  logic [31:0]                   wnew;
  logic [7:0]                    pad_byte;

  sha1_round u_round (
    .work_i (wk_q),
    .rnd_i  (rnd_q),
    .win_i  (buf_q),
    .work_o (wk_next),
    .wnew_o (wnew)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {5'b0, idx_q, h_q[idx_q]};
  assign m_axis_tlast_o  = (idx_q == sha1_pkg::WORD_LAST);
  assign pad_byte        = mark_q ? sha1_pkg::PAD_MARK : 8'h00;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    blk_d   = blk_q;
    mark_d  = mark_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    h_d     = h_q;
    buf_d   = buf_q;
    len_d   = len_q;
    wk_d    = wk_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == sha1_pkg::OP_FINISH) begin
            len_d   = {blk_q, fill_q, 3'b000};
            mark_d  = 1'b1;
            state_d = ST_PAD;
          end else begin
            buf_d  = {buf_q[503:0], s_axis_tdata_i};
            fill_d = fill_q + 6'd1;
            if (fill_q == sha1_pkg::FILL_LAST) begin
              blk_d   = blk_q + sha1_pkg::BLK_W'(1);
              wk_d    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
              rnd_d   = '0;
              ret_d   = ST_IDLE;
              state_d = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        buf_d  = {buf_q[503:0], pad_byte};
        mark_d = 1'b0;
        fill_d = fill_q + 6'd1;
        if (fill_q == sha1_pkg::FILL_LAST) begin
          wk_d    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          rnd_d   = '0;
          ret_d   = ST_PAD;
          state_d = ST_ROUND;
        end else if (fill_d == sha1_pkg::FILL_LEN_AT) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        buf_d  = {buf_q[503:0], len_q[63:56]};
        len_d  = {len_q[55:0], 8'h00};
        fill_d = fill_q + 6'd1;
        if (fill_q == sha1_pkg::FILL_LAST) begin
          wk_d    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          rnd_d   = '0;
          ret_d   = ST_OUT;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        wk_d  = wk_next;
        buf_d = {buf_q[479:0], wnew};
        rnd_d = rnd_q + sha1_pkg::RND_W'(1);
        if (rnd_q == sha1_pkg::RND_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        h_d[0]  = h_q[0] + wk_q.a;
        h_d[1]  = h_q[1] + wk_q.b;
        h_d[2]  = h_q[2] + wk_q.c;
        h_d[3]  = h_q[3] + wk_q.d;
        h_d[4]  = h_q[4] + wk_q.e;
        idx_d   = '0;
        state_d = ret_q;
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          if (idx_q == sha1_pkg::WORD_LAST) begin
            h_d     = sha1_pkg::IV;
            blk_d   = '0;
            fill_d  = '0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      fill_q  <= '0;
      blk_q   <= '0;
      mark_q  <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
      h_q     <= sha1_pkg::IV;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      blk_q   <= blk_d;
      mark_q  <= mark_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    len_q <= len_d;
    wk_q  <= wk_d;
  end

  `SHA1_ASSERT_IMP(a_no_in_while_out, m_axis_tvalid_o, !s_axis_tready_o, "input taken while digest pending")
  `SHA1_ASSERT_IMP(a_round_range, state_q == ST_ROUND, rnd_q <= sha1_pkg::RND_LAST, "round counter out of range")
  `SHA1_ASSERT_IMP(a_len_fill, state_q == ST_LEN, fill_q >= sha1_pkg::FILL_LEN_AT, "length field misplaced")
  `SHA1_ASSERT_NXT(a_reinit, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, (state_q == ST_IDLE) && (fill_q == 6'd0) && (h_q[0] == sha1_pkg::IV[0]), "engine not reinitialized")

endmodule

// ===== bench/tb_sha1_hash_engine.sv =====
// Self-checking testbench for the byte-stream SHA-1 hash engine.
`timescale 1ns / 100ps

module tb_sha1_hash_engine;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned ITEM_TARGET   = 370;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0; // [0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        m_axis_tlast_o;

  logic [7:0]   msg_block [64];
  logic [5:0]   block_fill;
  logic [63:0]  bits_hashed;
  logic [31:0]  chain [5];
  digest_word_t pending_words [$];

  bit idle_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned bytes_absorbed = 0;
  int unsigned messages_hashed = 0;
  int unsigned words_checked = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  sha1_hash_engine u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    block_fill  = '0;
    bits_hashed = '0;
    for (int i = 0; i < 5; i++) chain[i] = sha1_pkg::IV[i];
  endfunction

  function automatic void hash_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    msg_block[block_fill] = data;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) begin
      hash_block();
      bits_hashed += 64'd512;
    end
  endfunction

  function automatic void finish_digest();
    int unsigned pos;
    logic [63:0] total;
    digest_word_t dw;
    pos = block_fill;
    total = bits_hashed + 64'(pos) * 64'd8;
    msg_block[pos] = sha1_pkg::PAD_MARK;
    for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (block_fill >= sha1_pkg::FILL_LEN_AT) begin
      hash_block();
      for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) msg_block[63-i] = total[8*i +: 8];
    hash_block();
    for (int i = 0; i < 5; i++) begin
      dw.word  = chain[i];
      dw.index = 3'(i);
      dw.last  = (3'(i) == sha1_pkg::WORD_LAST);
      pending_words = {pending_words, dw};
    end
    restart_hash();
  endfunction

  task automatic send_item(input logic op, input logic [7:0] data);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (op == sha1_pkg::OP_ABSORB) begin
      absorb_byte(data);
      bytes_absorbed++;
    end else begin
      finish_digest();
      messages_hashed++;
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(sha1_pkg::OP_ABSORB, 8'($urandom));
    send_item(sha1_pkg::OP_FINISH, 8'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_message();
    send_item(sha1_pkg::OP_FINISH, 8'hFF);
    send_item(sha1_pkg::OP_FINISH, 8'h00);
    wait_drained();
  endtask

  task automatic test_byte_extremes();
    logic [7:0] pattern [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    foreach (pattern[i]) send_item(sha1_pkg::OP_ABSORB, pattern[i]);
    send_item(sha1_pkg::OP_FINISH, 8'h00);
    send_item(sha1_pkg::OP_ABSORB, 8'h61);
    send_item(sha1_pkg::OP_ABSORB, 8'h62);
    send_item(sha1_pkg::OP_ABSORB, 8'h63);
    send_item(sha1_pkg::OP_FINISH, 8'hFF);
    wait_drained();
  endtask

  task automatic test_block_boundaries();
    int unsigned lengths [4] = '{55, 56, 63, 64};
    foreach (lengths[i]) send_message(lengths[i]);
    wait_drained();
  endtask

  task automatic test_random_messages();
    while (items_sent < ITEM_TARGET - 90) begin
      if ($urandom_range(0, 5) == 0) send_message($urandom_range(50, 70));
      else send_message($urandom_range(0, 20));
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    while (items_sent < ITEM_TARGET) send_message($urandom_range(0, 24));
    wait_drained();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    digest_word_t exp_word;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_words.size() == 0) begin
        $error("Unexpected digest word %h", m_axis_tdata_o[31:0]);
        fail_count++;
      end else begin
        exp_word = pending_words.pop_front();
        words_checked++;
        if (m_axis_tdata_o[31:0] !== exp_word.word) begin
          $error("digest_word: expected %h, got %h", exp_word.word, m_axis_tdata_o[31:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[34:32] !== exp_word.index) begin
          $error("word_index: expected %0d, got %0d", exp_word.index, m_axis_tdata_o[34:32]);
          fail_count++;
        end
        if (m_axis_tlast_o !== exp_word.last) begin
          $error("last: expected %0b, got %0b", exp_word.last, m_axis_tlast_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    restart_hash();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_message();
    test_byte_extremes();
    test_block_boundaries();
    test_random_messages();
    test_back_to_back();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Hashed %0d messages from %0d bytes (%0d items), checked %0d digest words;",
             messages_hashed, bytes_absorbed, items_sent, words_checked);
    $display("covered empty input, byte extremes, block boundaries and two-block padding.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
